// ===== src/rsd_pkg.sv =====
// shared types, register codes and widening tables for the sprite decoder
`timescale 1ns / 1ps

package rsd_pkg;

  // depth of the queue between front and back
  localparam int unsigned RSD_QUEUE_DEPTH = 2;

  // saturation value of the column counter
  localparam logic [16:0] COL_MAX = 17'h1FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COLOR_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_OFFSET_X     = 3'd3,
    REG_OFFSET_Y     = 3'd4,
    REG_OUT_WIDTH    = 3'd5
  } cfg_idx_t;

  // pixel format codes
  localparam logic MODE_RGB555 = 1'b0;
  localparam logic MODE_RGB565 = 1'b1;

  // register view seen by front and back
  typedef struct packed {
    logic        color_mode;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] offset_x;
    logic [15:0] out_width;
    logic [31:0] base_prod;   // offset_y * out_width
  } rsd_cfg_t;

  // one classified word on its way to the back
  typedef struct packed {
    logic [31:0] row_base;
    logic [16:0] column;
    logic [15:0] word;
    logic        mode;
    logic        is_pixel;
    logic        image_end;
  } rsd_rec_t;

  typedef logic [31:0][7:0] w5_tab_t;
  typedef logic [63:0][7:0] w6_tab_t;

  // 5-bit channel: floor(c*8*1.03)
  function automatic w5_tab_t build_widen5();
    w5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 8 * 103) / 100);
    end
    return t;
  endfunction

  // 6-bit channel: floor(c*4*1.012)
  function automatic w6_tab_t build_widen6();
    w6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 4 * 253) / 250);
    end
    return t;
  endfunction

  localparam w5_tab_t WIDEN5 = build_widen5();
  localparam w6_tab_t WIDEN6 = build_widen6();

endpackage

// ===== src/rle_sprite_color_decoder_core.sv =====
// top level: configuration registers, front, queue and back of the decoder
// a result word is stored in the queue and then in the output register before it leaves
// throughput: one input word per cycle, header words included, as long as out_tready is high
// the queue between front and back lets the input keep flowing for two words while out stalls
// reset (synchronous, rst_n low) clears run and position state, restores register defaults
// and empties queue and output register; no memory clearing is needed
`timescale 1ns / 1ps

module rle_sprite_color_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = rsd_pkg::RSD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] data_word
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] pixel_address, [39:32] red, [47:40] green,
                                  // [55:48] blue
  output logic        out_tlast,  // image_end
  output logic        out_tuser   // [0] is_pixel
);
  import rsd_pkg::*;

  logic        color_mode_r;
  logic [15:0] image_width_r;
  logic [15:0] image_height_r;
  logic [15:0] offset_x_r;
  logic [15:0] offset_y_r;
  logic [15:0] out_width_r;
  logic [31:0] base_prod_r;

  logic        cfg_we;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] base_prod_nxt;

  rsd_cfg_t cfg;
  rsd_rec_t push_rec;
  rsd_rec_t pop_rec;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // origin row base follows every write, using the new value in place of the old
  assign mul_a         = (cfg_index == REG_OFFSET_Y)  ? cfg_data : offset_y_r;
  assign mul_b         = (cfg_index == REG_OUT_WIDTH) ? cfg_data : out_width_r;
  assign base_prod_nxt = mul_a * mul_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= MODE_RGB565;
      image_width_r  <= '0;
      image_height_r <= 16'd1;
      offset_x_r     <= '0;
      offset_y_r     <= '0;
      out_width_r    <= '0;
      base_prod_r    <= '0;
    end else if (cfg_we) begin
      base_prod_r <= base_prod_nxt;
      case (cfg_index)
        REG_COLOR_MODE:   color_mode_r   <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        REG_OFFSET_X:     offset_x_r     <= cfg_data;
        REG_OFFSET_Y:     offset_y_r     <= cfg_data;
        REG_OUT_WIDTH:    out_width_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.color_mode   = color_mode_r;
    cfg.image_width  = image_width_r;
    cfg.image_height = image_height_r;
    cfg.offset_x     = offset_x_r;
    cfg.out_width    = out_width_r;
    cfg.base_prod    = base_prod_r;
  end

  rsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  rsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty)
  );

  rsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_rec      (pop_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/rsd_front.sv =====
// front: accepts stream words, tracks runs and position, queues results
`timescale 1ns / 1ps

module rsd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  rsd_pkg::rsd_cfg_t cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output rsd_pkg::rsd_rec_t q_rec
);
  import rsd_pkg::*;

  logic        in_run_r, in_run_nxt;
  logic [7:0]  pixels_left_r, pixels_left_nxt;
  logic        eol_pending_r, eol_pending_nxt;
  logic [16:0] column_r, column_nxt;
  logic [15:0] row_r, row_nxt;
  logic [31:0] row_base_r, row_base_nxt;
  logic        base_valid_r, base_valid_nxt;

  logic        accept;
  logic [31:0] rb;
  logic [7:0]  count;
  logic [17:0] col_sum;
  logic [16:0] col_skip;
  logic [16:0] iw17;
  logic        fits;
  logic [15:0] row_inc;
  logic        line_done;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // header decode and fit check
  assign rb       = base_valid_r ? row_base_r : cfg.base_prod;
  assign count    = in_tdata[15:8];
  assign col_sum  = {1'b0, column_r} + {11'd0, in_tdata[6:0]};
  assign col_skip = col_sum[17] ? COL_MAX : col_sum[16:0];
  assign iw17     = {1'b0, cfg.image_width};
  assign fits     = (col_skip <= iw17) && ({9'd0, count} <= (iw17 - col_skip));
  assign row_inc  = row_r + 16'd1;

  // next position state and queued record
  always_comb begin
    in_run_nxt      = in_run_r;
    pixels_left_nxt = pixels_left_r;
    eol_pending_nxt = eol_pending_r;
    column_nxt      = column_r;
    row_nxt         = row_r;
    row_base_nxt    = row_base_r;
    base_valid_nxt  = base_valid_r;
    line_done       = 1'b0;
    q_push          = 1'b0;
    q_rec           = '0;
    if (accept) begin
      base_valid_nxt = 1'b1;
      row_base_nxt   = rb;
      if (in_run_r) begin
        q_push         = 1'b1;
        q_rec.row_base = rb;
        q_rec.column   = column_r;
        q_rec.word     = in_tdata;
        q_rec.mode     = cfg.color_mode;
        q_rec.is_pixel = 1'b1;
        if (column_r != COL_MAX) begin
          column_nxt = column_r + 17'd1;
        end
        pixels_left_nxt = pixels_left_r - 8'd1;
        if (pixels_left_r == 8'd1) begin
          in_run_nxt = 1'b0;
          if (eol_pending_r) begin
            eol_pending_nxt = 1'b0;
            line_done       = 1'b1;
          end
        end
      end else begin
        column_nxt = col_skip;
        if (fits && (count != 8'd0)) begin
          in_run_nxt      = 1'b1;
          pixels_left_nxt = count;
          eol_pending_nxt = in_tdata[7];
        end else if (in_tdata[7]) begin
          line_done = 1'b1;
        end
      end
      // end of line, possibly end of image
      if (line_done) begin
        row_nxt      = row_inc;
        column_nxt   = '0;
        row_base_nxt = rb + {16'd0, cfg.out_width};
        if ((row_inc >= cfg.image_height) || (cfg.image_height == 16'd0)) begin
          row_nxt         = '0;
          base_valid_nxt  = 1'b0;
          in_run_nxt      = 1'b0;
          pixels_left_nxt = '0;
          eol_pending_nxt = 1'b0;
          q_push          = 1'b1;
          q_rec.image_end = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r      <= 1'b0;
      pixels_left_r <= '0;
      eol_pending_r <= 1'b0;
      column_r      <= '0;
      row_r         <= '0;
      row_base_r    <= '0;
      base_valid_r  <= 1'b0;
    end else begin
      in_run_r      <= in_run_nxt;
      pixels_left_r <= pixels_left_nxt;
      eol_pending_r <= eol_pending_nxt;
      column_r      <= column_nxt;
      row_r         <= row_nxt;
      row_base_r    <= row_base_nxt;
      base_valid_r  <= base_valid_nxt;
    end
  end

endmodule

// ===== src/rsd_queue.sv =====
// small queue of classified words between front and back
`timescale 1ns / 1ps

module rsd_queue #(
  parameter int unsigned DEPTH = rsd_pkg::RSD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rsd_pkg::rsd_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output rsd_pkg::rsd_rec_t pop_rec,
  output logic              empty
);
  import rsd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  rsd_rec_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign pop_rec = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== src/rsd_back.sv =====
// back: address add and color widening into the output register
`timescale 1ns / 1ps

module rsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rsd_pkg::rsd_cfg_t cfg,
  input  logic              q_empty,
  input  rsd_pkg::rsd_rec_t q_rec,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import rsd_pkg::*;

  logic        valid_r;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic        pix_r;
  logic        end_r;
  logic        load;

  assign load  = !q_empty && (!valid_r || out_tready);
  assign q_pop = load;

  // destination address and widened channels
  always_comb begin
    addr_nxt  = '0;
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (q_rec.is_pixel) begin
      addr_nxt = q_rec.row_base + {16'd0, cfg.offset_x} + {15'd0, q_rec.column};
      blue_nxt = WIDEN5[q_rec.word[4:0]];
      if (q_rec.mode == MODE_RGB565) begin
        red_nxt   = WIDEN5[q_rec.word[15:11]];
        green_nxt = WIDEN6[q_rec.word[10:5]];
      end else begin
        red_nxt   = WIDEN5[q_rec.word[14:10]];
        green_nxt = WIDEN5[q_rec.word[9:5]];
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      addr_r  <= addr_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      pix_r   <= q_rec.is_pixel;
      end_r   <= q_rec.image_end;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {blue_r, green_r, red_r, addr_r};
  assign out_tlast  = end_r;
  assign out_tuser  = pix_r;

endmodule
